@@ rtl/core/discrete_log_baby_giant_step_unit_macros.svh @@
// Assertion macros shared by the discrete log unit
`ifndef DISCRETE_LOG_BABY_GIANT_STEP_UNIT_MACROS_SVH
`define DISCRETE_LOG_BABY_GIANT_STEP_UNIT_MACROS_SVH
// implication checked on every clock, quiet during reset
`define DLB_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// implication checked on the next clock
`define DLB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ rtl/core/dlb_pkg.sv @@
// Package: widths, status codes, sequencer states and unit command types
package dlb_pkg;
   localparam int MOD_BITS    = 20;
   localparam int TABLE_DEPTH = 1025;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int LOG_BITS    = 21;
   localparam int CSR_BITS    = 1;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_NONE  = 2'd1,
      ST_NOINV = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_MODULUS   = 1'b0,
      CSR_GENERATOR = 1'b1
   } csr_index_type;

   // shared unit operations
   typedef enum logic [1:0] {
      OP_MULMOD = 2'd0,
      OP_DIVMOD = 2'd1,
      OP_ISQRT  = 2'd2
   } op_type;

   typedef struct packed {
      logic                      start;
      op_type                    op;
      logic [2*MOD_BITS-1:0]     a;
      logic [MOD_BITS-1:0]       b;
   } unit_cmd_type;

   typedef struct packed {
      logic                      done;
      logic [2*MOD_BITS-1:0]     quo;
      logic [MOD_BITS-1:0]       rem;
   } unit_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SQRT, S_SQRT_W, S_ZERO, S_TAB, S_TAB_W, S_INV_DIV, S_INV_DIV_W,
      S_INV_T, S_INV_T_W, S_RD, S_CMP, S_GMUL, S_GMUL_W, S_DONE
   } state_type;
endpackage

@@ rtl/core/dlb_arith.sv @@
// Shared iterative unit: multiply then reduce, divide, integer square root
module dlb_arith (
   input  logic                 clock,
   input  logic                 reset,
   input  dlb_pkg::unit_cmd_type cmd,
   output dlb_pkg::unit_rsp_type rsp
);
   import dlb_pkg::*;
   localparam int AW = 2 * MOD_BITS;
   localparam int CW = $clog2(AW + 1);

   logic              busy_ff, busy_in;
   op_type            op_ff, op_in;
   logic [AW-1:0]     quo_ff, quo_in;
   logic [AW:0]       rem_ff, rem_in;     // remainder / sqrt work value
   logic [AW-1:0]     num_ff, num_in;     // numerator shifted out msb first
   logic [MOD_BITS-1:0] div_ff, div_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [AW:0]       trial;
   logic [AW:0]       sq_t;

   // one bit per cycle: restoring division, or digit-by-digit square root
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = '0;
      sq_t    = '0;
      if (!busy_ff && cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         div_in  = cmd.b;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = CW'(AW);
         if (cmd.op == OP_MULMOD) begin
            num_in = cmd.a[MOD_BITS-1:0] * cmd.b;
         end else begin
            num_in = cmd.a;
         end
         if (cmd.op == OP_MULMOD) begin
            div_in = cmd.a[AW-1:MOD_BITS];
         end
         if (cmd.op == OP_ISQRT) begin
            cnt_in = CW'(AW / 2);
         end
      end else if (busy_ff) begin
         if (op_ff == OP_ISQRT) begin
            // rem holds remainder, quo holds root
            trial  = {rem_ff[AW-2:0], num_ff[AW-1:AW-2]};
            sq_t   = {1'b0, quo_ff[AW-3:0], 2'b01};
            num_in = {num_ff[AW-3:0], 2'b00};
            if (trial >= sq_t) begin
               rem_in = trial - sq_t;
               quo_in = {quo_ff[AW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[AW-2:0], 1'b0};
            end
         end else begin
            trial  = {rem_ff[AW-1:0], num_ff[AW-1]};
            num_in = {num_ff[AW-2:0], 1'b0};
            if (trial >= {{(AW+1-MOD_BITS){1'b0}}, div_ff}) begin
               rem_in = trial - {{(AW+1-MOD_BITS){1'b0}}, div_ff};
               quo_in = {quo_ff[AW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[AW-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff[MOD_BITS-1:0];
endmodule

@@ rtl/core/dlb_seq.sv @@
// Sequencer: square root, table fill, inverse, giant-step search
module dlb_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dlb_pkg::MOD_BITS-1:0]  target,
   input  logic [dlb_pkg::MOD_BITS-1:0]  modulus,
   input  logic [dlb_pkg::MOD_BITS-1:0]  generator,
   output logic                          busy,
   output logic                          rsp_valid,
   output dlb_pkg::status_type           rsp_status,
   output logic [dlb_pkg::LOG_BITS-1:0]  rsp_log_value,
   output dlb_pkg::unit_cmd_type         cmd,
   input  dlb_pkg::unit_rsp_type         ursp
);
   import dlb_pkg::*;
   `include "discrete_log_baby_giant_step_unit_macros.svh"
   localparam int AW = 2 * MOD_BITS;
   localparam int SW = MOD_BITS + 2;   // signed Bezout coefficient

   state_type state_ff, state_in;
   logic [MOD_BITS-1:0] n_ff, n_in, g_ff, g_in, beta_ff, beta_in;
   logic [MOD_BITS-1:0] giant_ff, giant_in, inv_ff, inv_in, prev_ff, prev_in;
   logic [IDX_BITS-1:0] k_ff, k_in, j_ff, j_in, i_ff, i_in;
   logic [MOD_BITS-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic signed [SW-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [MOD_BITS-1:0] q_ff, q_in;
   logic [LOG_BITS-1:0] acc_ff, acc_in;          // i*k kept as a running sum
   logic                 vld_ff, vld_in;
   status_type           st_ff, st_in;
   logic [LOG_BITS-1:0] log_ff, log_in;
   logic signed [2*SW-1:0] qt;
   logic signed [SW-1:0]   t_new;

   // table memory
   logic [MOD_BITS-1:0] mem [TABLE_DEPTH];
   logic                 we;
   logic [IDX_BITS-1:0] waddr, raddr;
   logic [MOD_BITS-1:0] wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; g_in = g_ff; beta_in = beta_ff;
      giant_in = giant_ff; inv_in = inv_ff; prev_in = prev_ff;
      k_in = k_ff; j_in = j_ff; i_in = i_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff; q_in = q_ff;
      acc_in = acc_ff;
      vld_in = 1'b0; st_in = st_ff; log_in = log_ff;
      qt = $signed({2'b00, q_ff}) * t1_ff;
      t_new = t0_ff - qt[SW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in = modulus; g_in = generator; beta_in = target;
               state_in = S_SQRT;
            end
         end
         S_SQRT: state_in = S_SQRT_W;
         S_SQRT_W: begin
            if (ursp.done) begin
               if (ursp.quo + AW'(1) > AW'(TABLE_DEPTH - 1)) begin
                  k_in = IDX_BITS'(TABLE_DEPTH - 1);
               end else begin
                  k_in = IDX_BITS'(ursp.quo + AW'(1));
               end
               j_in = '0;
               prev_in = MOD_BITS'(1);
               if (n_ff < MOD_BITS'(2)) begin
                  state_in = S_ZERO;
               end else begin
                  state_in = S_TAB;
               end
            end
         end
         S_ZERO: begin
            j_in = j_ff + 1'b1;
            if (j_ff == k_ff) begin
               st_in = ST_NOINV; log_in = '0; vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TAB: begin
            // entry j written from prev; advance unless last
            if (j_ff == k_ff) begin
               r0_in = n_ff; r1_in = prev_ff;
               t0_in = '0; t1_in = SW'(1);
               state_in = S_INV_DIV;
            end else begin
               state_in = S_TAB_W;
            end
         end
         S_TAB_W: begin
            if (ursp.done) begin
               prev_in = ursp.rem;
               j_in = j_ff + 1'b1;
               state_in = S_TAB;
            end
         end
         S_INV_DIV: begin
            if (r1_ff == '0) begin
               if (r0_ff != MOD_BITS'(1)) begin
                  st_in = ST_NOINV; log_in = '0; vld_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  inv_in = t0_ff[SW-1] ? MOD_BITS'(t0_ff + $signed({2'b00, n_ff}))
                                       : t0_ff[MOD_BITS-1:0];
                  giant_in = beta_ff;
                  i_in = '0; j_in = '0; acc_in = '0;
                  state_in = S_RD;
               end
            end else begin
               state_in = S_INV_DIV_W;
            end
         end
         S_INV_DIV_W: begin
            if (ursp.done) begin
               q_in = ursp.quo[MOD_BITS-1:0];
               r0_in = r1_ff; r1_in = ursp.rem;
               state_in = S_INV_T;
            end
         end
         S_INV_T: begin
            t0_in = t1_ff; t1_in = t_new;
            state_in = S_INV_DIV;
         end
         S_INV_T_W: state_in = S_INV_DIV;
         S_RD: state_in = S_CMP;
         S_CMP: begin
            if (rdata_ff == giant_ff) begin
               st_in = ST_FOUND;
               log_in = acc_ff + LOG_BITS'(j_ff);
               vld_in = 1'b1;
               state_in = S_IDLE;
            end else if (j_ff == k_ff) begin
               if (i_ff == k_ff) begin
                  st_in = ST_NONE; log_in = '0; vld_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_GMUL;
               end
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_GMUL: state_in = S_GMUL_W;
         S_GMUL_W: begin
            if (ursp.done) begin
               giant_in = ursp.rem;
               i_in = i_ff + 1'b1;
               acc_in = acc_ff + LOG_BITS'(k_ff);
               j_in = '0;
               state_in = S_RD;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // unit commands and memory controls
   always_comb begin
      cmd = '0;
      we = 1'b0; waddr = j_ff; wdata = prev_ff; raddr = j_ff;
      unique case (state_ff)
         S_SQRT: begin
            cmd.start = 1'b1; cmd.op = OP_ISQRT;
            cmd.a = AW'(n_ff);
         end
         S_ZERO: begin
            we = 1'b1; wdata = '0;
         end
         S_TAB: begin
            we = 1'b1;
            if (j_ff != k_ff) begin
               cmd.start = 1'b1; cmd.op = OP_MULMOD;
               cmd.a = {n_ff, prev_ff}; cmd.b = g_ff;
            end
         end
         S_INV_DIV: begin
            if (r1_ff != '0) begin
               cmd.start = 1'b1; cmd.op = OP_DIVMOD;
               cmd.a = AW'(r0_ff); cmd.b = r1_ff;
            end
         end
         S_GMUL: begin
            cmd.start = 1'b1; cmd.op = OP_MULMOD;
            cmd.a = {n_ff, giant_ff}; cmd.b = inv_ff;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      n_ff <= n_in; g_ff <= g_in; beta_ff <= beta_in;
      giant_ff <= giant_in; inv_ff <= inv_in; prev_ff <= prev_in;
      k_ff <= k_in; j_ff <= j_in; i_ff <= i_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in; q_ff <= q_in;
      acc_ff <= acc_in; st_ff <= st_in; log_ff <= log_in;
   end

   assign busy          = (state_ff != S_IDLE) || vld_ff;
   assign rsp_valid     = vld_ff;
   assign rsp_status    = st_ff;
   assign rsp_log_value = log_ff;

   `DLB_ASSERT_NEXT(a_start_leaves_idle, clock, reset,
      state_ff == S_IDLE && start, state_ff == S_SQRT)
   `DLB_ASSERT_IMP(a_j_in_range, clock, reset, state_ff == S_CMP, j_ff <= k_ff)
   `DLB_ASSERT_IMP(a_found_zero_log, clock, reset, vld_ff && st_ff != ST_FOUND, log_ff == '0)
endmodule

@@ rtl/core/discrete_log_baby_giant_step_unit.sv @@
// Top level of the discrete log unit: config registers, sequencer, shared unit
// Steps of a request: the root, the table fill, the inverse steps, then the
// table compares, with a multiply for each giant step.
// One word at a time: busy stays high from start until the result strobe.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous reset: modulus 65539, generator 2, sequencer idle.
module discrete_log_baby_giant_step_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dlb_pkg::MOD_BITS-1:0]    req_target,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [dlb_pkg::LOG_BITS-1:0]    rsp_log_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dlb_pkg::CSR_BITS-1:0]    csr_index,
   input  logic [dlb_pkg::MOD_BITS-1:0]    csr_data
);
   import dlb_pkg::*;
   logic [MOD_BITS-1:0] modulus_ff, generator_ff;
   unit_cmd_type cmd;
   unit_rsp_type ursp;
   status_type   st;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MOD_BITS'(65539);
         generator_ff <= MOD_BITS'(2);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODULUS:   modulus_ff   <= csr_data;
            CSR_GENERATOR: generator_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dlb_seq u_seq (
      .clock(clock), .reset(reset), .start(start && !busy), .target(req_target),
      .modulus(modulus_ff), .generator(generator_ff), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_status(st), .rsp_log_value(rsp_log_value),
      .cmd(cmd), .ursp(ursp)
   );

   dlb_arith u_arith (.clock(clock), .reset(reset), .cmd(cmd), .rsp(ursp));

   assign rsp_status = st;
endmodule
